// ----- hw/rtl/slls_pkg.sv -----
// shared types, constants and the ln_step helper function of the sound level log scaler
package slls_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SCALE_SHIFT = 10;
  localparam int SCALE_MUL_W = 7;
  localparam int PROD_W      = SAMPLE_BITS + SCALE_MUL_W;
  localparam int SCALED_W    = PROD_W - SCALE_SHIFT;
  localparam int V_W         = 15;
  localparam int X_W         = 32;
  localparam int FRAC_W      = 16;
  localparam int LN_W        = 22;
  localparam int IP_W        = LN_W - 1 - FRAC_W;
  localparam int TENTHS_W    = 6;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int LEVEL_W     = 11;
  localparam int SLOPE_PROD_W = CFG_W + TENTHS_W;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_PROD_W = SLOPE_PROD_W + RECIP_W;
  localparam int LN_STEPS    = 7;
  localparam int STEP_IDX_W  = $clog2(LN_STEPS);

  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL  = SCALE_MUL_W'(125);
  localparam logic [RECIP_W-1:0]     RECIP_TEN  = RECIP_W'(52429);
  localparam logic [TENTHS_W-1:0]    TENTHS_MAX = TENTHS_W'(63);

  localparam logic signed [LN_W-1:0] LN_INIT    = LN_W'(32'h000a65af);
  localparam logic signed [LN_W-1:0] LN_SHIFT8  = LN_W'(32'h00058b91);
  localparam logic signed [LN_W-1:0] LN_SHIFT4  = LN_W'(32'h0002c5c8);
  localparam logic signed [LN_W-1:0] LN_SHIFT2  = LN_W'(32'h000162e4);
  localparam logic signed [LN_W-1:0] LN_SHIFT1  = LN_W'(32'h0000b172);
  localparam logic [X_W-1:0]         X_ONE      = 32'h8000_0000;

  localparam logic signed [LN_W-1:0] STEP_LN [LN_STEPS] = '{
    LN_W'(32'h067cd), LN_W'(32'h03920), LN_W'(32'h01e27), LN_W'(32'h00f85),
    LN_W'(32'h007e1), LN_W'(32'h003f8), LN_W'(32'h001fe)
  };

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SLOPE  = CFG_IDX_W'(1);

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic [X_W-1:0]         x;
    logic signed [LN_W-1:0] y;
  } ln_stage_t;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic signed [LN_W-1:0] y;
  } ln_res_t;

  function automatic ln_stage_t ln_step(ln_stage_t s, int k);
    ln_stage_t r;
    logic [X_W-1:0] t;
    r = s;
    t = s.x + (s.x >> k);
    if (!t[X_W-1]) begin
      r.x = t;
      r.y = s.y - STEP_LN[STEP_IDX_W'(k - 1)];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/sound_level_log_scaler.sv -----
// top level of the sound level log scaler: config registers and pipeline
// Usage:
//   A request is taken at each rising edge with start_i high and busy_o low.
//   busy_o is always low, so one sample can enter every clock cycle.
//   sample_i is an unsigned ADC conversion result.
//   Each result appears on level_o, log_tenths_o and zero_input_o for one
//   cycle with done_o high, after its request passes scaling, one
//   normalize stage, seven shift-add log stages, a residual stage, a tenths
//   stage and two multiplier stages for the slope/10 scaling.
//   Results come out in request order, one per request.
//   Throughput is one sample per cycle, set by the one-step-per-stage log chain.
//   The config channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
//   is always ready; index 0 is level_offset, index 1 is level_slope, other
//   indexes are ignored. Write config only while no request is in flight.
//   Reset clears all valid bits and loads offset 10 and slope 16.
//   The receiver cannot stall; a result is gone after its strobe cycle.
module sound_level_log_scaler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [slls_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic                              done_o,
  output logic [slls_pkg::LEVEL_W-1:0]      level_o,
  output logic [slls_pkg::TENTHS_W-1:0]     log_tenths_o,
  output logic                              zero_input_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [slls_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [slls_pkg::CFG_W-1:0]        cfg_data_i
);
  import slls_pkg::*;

  logic [CFG_W-1:0] level_offset_q, level_offset_d;
  logic [CFG_W-1:0] level_slope_q, level_slope_d;
  logic             accept;
  ln_stage_t        front_stage;
  ln_res_t          ln_res;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  always_comb begin
    level_offset_d = level_offset_q;
    level_slope_d  = level_slope_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LEVEL_OFFSET: level_offset_d = cfg_data_i;
        CFG_LEVEL_SLOPE:  level_slope_d  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_offset_q <= CFG_W'(10);
      level_slope_q  <= CFG_W'(16);
    end else begin
      level_offset_q <= level_offset_d;
      level_slope_q  <= level_slope_d;
    end
  end

  slls_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .sample_i (sample_i),
    .stage_o  (front_stage)
  );

  slls_ln_steps u_ln_steps (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (front_stage),
    .res_o   (ln_res)
  );

  slls_level u_level (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (ln_res),
    .level_offset_i (level_offset_q),
    .level_slope_i  (level_slope_q),
    .done_o         (done_o),
    .level_o        (level_o),
    .log_tenths_o   (log_tenths_o),
    .zero_input_o   (zero_input_o)
  );

endmodule

// ----- hw/rtl/slls_front.sv -----
// input scaling by 125/1024 and normalizing shifts of the log
module slls_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [slls_pkg::SAMPLE_BITS-1:0]  sample_i,
  output slls_pkg::ln_stage_t               stage_o
);
  import slls_pkg::*;

  logic                 s1_valid_q;
  logic [SCALED_W-1:0]  scaled_q;
  logic [SCALED_W-1:0]  scaled_d;
  logic [PROD_W-1:0]    prod;
  ln_stage_t            stage_q;
  ln_stage_t            stage_d;
  logic [V_W-1:0]       m;
  logic signed [LN_W-1:0] y;

  assign prod     = PROD_W'(sample_i) * PROD_W'(SCALE_MUL);
  assign scaled_d = prod[PROD_W-1:SCALE_SHIFT];

  always_comb begin
    m = V_W'(scaled_q);
    y = LN_INIT;
    if (m < V_W'(1 << 7)) begin
      m = m << 8;
      y = y - LN_SHIFT8;
    end
    if (m < V_W'(1 << 11)) begin
      m = m << 4;
      y = y - LN_SHIFT4;
    end
    if (m < V_W'(1 << 13)) begin
      m = m << 2;
      y = y - LN_SHIFT2;
    end
    if (m < V_W'(1 << 14)) begin
      m = m << 1;
      y = y - LN_SHIFT1;
    end
    stage_d.valid = s1_valid_q;
    stage_d.zero  = (scaled_q == '0);
    stage_d.x     = {1'b0, m, {FRAC_W{1'b0}}};
    stage_d.y     = y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      stage_q    <= '0;
    end else begin
      s1_valid_q <= valid_i;
      stage_q    <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scaled_q <= scaled_d;
  end

  assign stage_o = stage_q;

endmodule

// ----- hw/rtl/slls_ln_steps.sv -----
// shift-add log steps, one per stage, and the residual correction
module slls_ln_steps (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slls_pkg::ln_stage_t stage_i,
  output slls_pkg::ln_res_t   res_o
);
  import slls_pkg::*;

  ln_stage_t stage_q [LN_STEPS];
  ln_res_t   res_q;
  ln_res_t   res_d;
  logic [X_W-1:0] resid;

  for (genvar i = 0; i < LN_STEPS; i++) begin : g_step
    ln_stage_t prev;
    if (i == 0) begin : g_first
      assign prev = stage_i;
    end else begin : g_next
      assign prev = stage_q[i-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q[i] <= '0;
      end else begin
        stage_q[i] <= ln_step(prev, i + 1);
      end
    end
  end

  always_comb begin
    resid       = X_ONE - stage_q[LN_STEPS-1].x;
    res_d.valid = stage_q[LN_STEPS-1].valid;
    res_d.zero  = stage_q[LN_STEPS-1].zero;
    res_d.y     = stage_q[LN_STEPS-1].y - $signed(LN_W'(resid >> 15));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/slls_level.sv -----
// log to tenths, saturation and level scaling by slope/10 plus offset
module slls_level (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slls_pkg::ln_res_t             res_i,
  input  logic [slls_pkg::CFG_W-1:0]    level_offset_i,
  input  logic [slls_pkg::CFG_W-1:0]    level_slope_i,
  output logic                          done_o,
  output logic [slls_pkg::LEVEL_W-1:0]  level_o,
  output logic [slls_pkg::TENTHS_W-1:0] log_tenths_o,
  output logic                          zero_input_o
);
  import slls_pkg::*;

  localparam int SUM_W = IP_W + 4 + 1;

  logic [LN_W-1:0]         uy;
  logic [IP_W-1:0]         ip;
  logic [FRAC_W-1:0]       fp;
  logic [FRAC_W+3:0]       fp10;
  logic [SUM_W-1:0]        sum;
  logic [TENTHS_W-1:0]     tenths_d;

  logic                    t_valid_q, p_valid_q, o_valid_q;
  logic                    t_zero_q, p_zero_q, o_zero_q;
  logic [TENTHS_W-1:0]     t_tenths_q, p_tenths_q, o_tenths_q;
  logic [SLOPE_PROD_W-1:0] sprod_q;
  logic [SLOPE_PROD_W-1:0] sprod_d;
  logic [RECIP_PROD_W-1:0] rprod;
  logic [LEVEL_W-1:0]      level_d;
  logic [LEVEL_W-1:0]      level_q;

  always_comb begin
    uy   = res_i.y[LN_W-1] ? '0 : res_i.y;
    ip   = uy[LN_W-2:FRAC_W];
    fp   = uy[FRAC_W-1:0];
    fp10 = (20'(fp) << 3) + (20'(fp) << 1);
    sum  = (SUM_W'(ip) << 3) + (SUM_W'(ip) << 1) + SUM_W'(fp10[FRAC_W+3:FRAC_W]);
    if (res_i.zero) begin
      tenths_d = '0;
    end else if (sum > SUM_W'(TENTHS_MAX)) begin
      tenths_d = TENTHS_MAX;
    end else begin
      tenths_d = sum[TENTHS_W-1:0];
    end
  end

  assign sprod_d = SLOPE_PROD_W'(level_slope_i) * SLOPE_PROD_W'(t_tenths_q);
  assign rprod   = RECIP_PROD_W'(sprod_q) * RECIP_PROD_W'(RECIP_TEN);
  assign level_d = LEVEL_W'(level_offset_i) + LEVEL_W'(rprod[RECIP_PROD_W-1:RECIP_SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      t_valid_q <= res_i.valid;
      p_valid_q <= t_valid_q;
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_zero_q   <= res_i.zero;
    t_tenths_q <= tenths_d;
    p_zero_q   <= t_zero_q;
    p_tenths_q <= t_tenths_q;
    sprod_q    <= sprod_d;
    o_zero_q   <= p_zero_q;
    o_tenths_q <= p_tenths_q;
    level_q    <= level_d;
  end

  assign done_o       = o_valid_q;
  assign level_o      = level_q;
  assign log_tenths_o = o_tenths_q;
  assign zero_input_o = o_zero_q;

endmodule

// ----- verif/testbench.sv -----
// testbench of the sound level log scaler: random and corner samples checked against a predictor
module testbench;
  import slls_pkg::*;

  localparam int LATENCY = 13;
  localparam int IDLE_LIMIT = 1000;
  localparam int unsigned SCALE_NUM = 125;
  localparam int unsigned RST_OFFSET = 10;
  localparam int unsigned RST_SLOPE = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [TENTHS_W-1:0] tenths;
    logic                zero;
  } level_result_t;

  class level_scoreboard;
    level_result_t pending[$];
    int unsigned   offset;
    int unsigned   slope;
    int            errors;

    function new();
      offset = RST_OFFSET;
      slope  = RST_SLOPE;
      errors = 0;
    endfunction

    function int signed step_ln(int k);
      case (k)
        1: return 32'h067cd;
        2: return 32'h03920;
        3: return 32'h01e27;
        4: return 32'h00f85;
        5: return 32'h007e1;
        6: return 32'h003f8;
        default: return 32'h001fe;
      endcase
    endfunction

    // natural log in 16.16, v >= 1
    function int signed ln_q16(int unsigned v);
      logic [31:0] x;
      logic [31:0] t;
      int signed   y;
      int          k;
      x = v << 16;
      y = 32'h000a65af;
      if (x < 32'h0000_8000) begin x = x << 16; y = y - 32'h000b1721; end
      if (x < 32'h0080_0000) begin x = x << 8;  y = y - 32'h00058b91; end
      if (x < 32'h0800_0000) begin x = x << 4;  y = y - 32'h0002c5c8; end
      if (x < 32'h2000_0000) begin x = x << 2;  y = y - 32'h000162e4; end
      if (x < 32'h4000_0000) begin x = x << 1;  y = y - 32'h0000b172; end
      for (k = 1; k <= 7; k++) begin
        t = x + (x >> k);
        if (!t[31]) begin
          x = t;
          y = y - step_ln(k);
        end
      end
      x = 32'h8000_0000 - x;
      y = y - int'(x >> 15);
      return y;
    endfunction

    function level_result_t predict_level(logic [SAMPLE_BITS-1:0] smp);
      level_result_t r;
      int unsigned   scaled;
      int unsigned   ulog;
      int unsigned   tenths;
      int signed     lg;
      scaled = (32'(smp) * SCALE_NUM) >> 10;
      tenths = 0;
      r.zero = (scaled == 0);
      if (scaled != 0) begin
        lg = ln_q16(scaled);
        ulog = (lg < 0) ? 0 : lg;
        tenths = (ulog >> 16) * 10 + (((ulog & 32'h0ffff) * 10) >> 16);
        if (tenths > TENTHS_MAX) tenths = TENTHS_MAX;
      end
      r.tenths = tenths[TENTHS_W-1:0];
      r.level  = LEVEL_W'(offset + (slope * tenths) / 10);
      return r;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LEVEL_OFFSET: offset = data;
        CFG_LEVEL_SLOPE:  slope  = data;
        default: ;
      endcase
    endtask

    task note_sample(logic [SAMPLE_BITS-1:0] smp);
      pending.push_back(predict_level(smp));
    endtask

    task check_result(logic [LEVEL_W-1:0] level, logic [TENTHS_W-1:0] tenths, logic zero);
      level_result_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      exp_r = pending.pop_front();
      if (level !== exp_r.level)
        report_mismatch($sformatf("level %0d, expected %0d", level, exp_r.level));
      if (tenths !== exp_r.tenths)
        report_mismatch($sformatf("log_tenths %0d, expected %0d", tenths, exp_r.tenths));
      if (zero !== exp_r.zero)
        report_mismatch($sformatf("zero_input %0b, expected %0b", zero, exp_r.zero));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic [SAMPLE_BITS-1:0] sample_i = '0;
  logic                   done_o;
  logic [LEVEL_W-1:0]     level_o;
  logic [TENTHS_W-1:0]    log_tenths_o;
  logic                   zero_input_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  level_scoreboard sb = new();
  int idle_cycles = 0;

  logic [SAMPLE_BITS-1:0] corner_samples [19] = '{
    12'd0, 12'd1, 12'd8, 12'd9, 12'd10, 12'd16, 12'd17, 12'd25, 12'd100, 12'd512,
    12'd1023, 12'd1024, 12'd2047, 12'd2048, 12'haaa, 12'h555, 12'd2730, 12'd4094, 12'd4095
  };

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sound_level_log_scaler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .sample_i    (sample_i),
    .done_o      (done_o),
    .level_o     (level_o),
    .log_tenths_o(log_tenths_o),
    .zero_input_o(zero_input_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) sb.check_result(level_o, log_tenths_o, zero_input_o);
      if (start_i && busy_o === 1'b0) sb.note_sample(sample_i);
      if (cfg_valid_i && cfg_ready_o === 1'b1) sb.write_register(cfg_index_i, cfg_data_i);
    end
    if ((start_i && busy_o === 1'b0) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task send_sample(logic [SAMPLE_BITS-1:0] smp);
    start_i  <= 1'b1;
    sample_i <= smp;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task pause(int n);
    start_i  <= 1'b0;
    sample_i <= SAMPLE_BITS'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  task drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_BITS'($urandom_range(0, 20));
      1: return SAMPLE_BITS'($urandom_range(4000, 4095));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // bursts of random length, gaps of random length, some back to back
  task run_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < count) begin
        send_sample(pick_sample());
        burst--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
    end
  endtask

  initial begin
    int unsigned offs [6];
    int unsigned slopes [6];
    int ph;
    offs   = '{0, 255, 0, 255, $urandom_range(0, 255), $urandom_range(0, 255)};
    slopes = '{0, 255, 255, 0, $urandom_range(0, 255), $urandom_range(0, 255)};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of offset and slope
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    pause(3);

    for (ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_LEVEL_OFFSET, CFG_W'(offs[ph]));
      write_cfg(CFG_LEVEL_SLOPE, CFG_W'(slopes[ph]));
      if (ph == 2) write_cfg(CFG_SPARE_LO, CFG_W'($urandom));
      if (ph == 3) write_cfg(CFG_SPARE_HI, CFG_W'($urandom));
      run_random(255);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
